### design/json_string_unescape_top_defines.svh
// ----------------------------------------------------------------------------
// JSON string unescape: assertion macros
// Concurrent assertion wrappers shared by the RTL; define ASSERT_OFF to drop
// them from a build.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define JSU_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define JSU_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape: shared package
// Character codes, UTF-8 constants, the result group type and the small
// per-byte helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;

  localparam logic [7:0] CTRL_BS = 8'h08;
  localparam logic [7:0] CTRL_FF = 8'h0C;
  localparam logic [7:0] CTRL_LF = 8'h0A;
  localparam logic [7:0] CTRL_CR = 8'h0D;
  localparam logic [7:0] CTRL_HT = 8'h09;

  localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0]  UTF8_CONT    = 8'h80;
  localparam logic [15:0] UTF8_LIM1    = 16'h0080;
  localparam logic [15:0] UTF8_LIM2    = 16'h0800;

  // Value returned by hex_value for a byte that is no hex digit.
  localparam logic [4:0] HEX_NONE = 5'd16;

  // Up to three decoded bytes produced by one input byte.
  typedef struct packed {
    logic [2:0][7:0] bytes;     // bytes[0] leaves first
    logic [1:0]      cnt;       // number of results, 0 for none
    logic            has_byte;  // 0 only for a bare end marker
    logic            last;      // group closes the string
  } jsu_group_t;

  function automatic logic [7:0] simple_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_LOWER_B: r = CTRL_BS;
      CH_LOWER_F: r = CTRL_FF;
      CH_LOWER_N: r = CTRL_LF;
      CH_LOWER_R: r = CTRL_CR;
      CH_LOWER_T: r = CTRL_HT;
      default:    r = c;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = 5'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      r = 5'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      r = 5'(c - 8'h37);
    end else begin
      r = HEX_NONE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// JSON string unescape: top level
// Streaming decoder for the body of one JSON string, one raw byte in and
// one decoded byte out per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one raw string byte per transfer,
//   in_last on the byte just before the closing quote.
//   Result channel (out_valid / out_stall): one decoded byte per transfer,
//   out_has_byte low only on a bare end marker, out_last on the final result.
//   The first result of a byte is offered in the cycle after its input
//   transfer. Throughput: one input byte per cycle while each byte completes
//   at most one result and the receiver does not stall; a byte that completes
//   more results (a \uXXXX escape gives up to three) holds the input while the
//   single result group register drains them, one byte per unstalled cycle.
//   Reset: synchronous, active low; returns to normal mode and empties the
//   result register. The input is taken again in the cycle after reset.
//   Receiver stall: the result held steady; the input is stalled once the
//   group register cannot drain in the same cycle, so no byte is lost.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_top_defines.svh"

module json_string_unescape_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_has_byte,
  output logic            out_last
);

  jsu_pkg::jsu_group_t dec_grp;
  jsu_pkg::jsu_group_t grp_r, grp_nxt;
  logic                grp_valid_r, grp_valid_nxt;

  logic in_xfer;
  logic out_xfer;
  logic draining;

  // Decode each accepted byte; the decoder advances its state on transfer.
  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_xfer),
    .in_byte (in_byte),
    .in_last (in_last),
    .grp     (dec_grp)
  );

  // The group register frees up when its final byte leaves this cycle.
  assign out_xfer = grp_valid_r && !out_stall;
  assign draining = out_xfer && (grp_r.cnt == 2'd1);
  assign in_stall = grp_valid_r && !draining;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    grp_nxt       = grp_r;
    grp_valid_nxt = grp_valid_r;
    if (in_xfer && dec_grp.cnt != 2'd0) begin
      // load a fresh group; a byte that completes nothing leaves no trace
      grp_nxt       = dec_grp;
      grp_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      if (grp_r.cnt == 2'd1) begin
        grp_valid_nxt = 1'b0;
      end else begin
        // advance the next byte to the head
        grp_nxt.bytes = {8'h00, grp_r.bytes[2], grp_r.bytes[1]};
        grp_nxt.cnt   = grp_r.cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
    end else begin
      grp_valid_r <= grp_valid_nxt;
    end
  end

  // Payload: no reset needed, only read while grp_valid_r is set.
  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  assign out_valid    = grp_valid_r;
  assign out_byte     = grp_r.bytes[0];
  assign out_has_byte = grp_r.has_byte;
  assign out_last     = grp_r.last && (grp_r.cnt == 2'd1);

  // Input is only held back while a group is waiting.
  `JSU_ASSERT_HOLDS(a_stall_needs_group, clk, rst_n,
                    !grp_valid_r |-> !in_stall, "in_stall without a pending group")
  // A pending group always carries at least one result.
  `JSU_ASSERT_HOLDS(a_group_nonempty, clk, rst_n,
                    grp_valid_r |-> grp_r.cnt != 2'd0, "empty group held")
  // A bare end marker only ever closes a string.
  `JSU_ASSERT_HOLDS(a_marker_is_last, clk, rst_n,
                    out_valid && !out_has_byte |-> out_last, "end marker not last")
  // Remaining bytes of a group follow without a gap.
  `JSU_ASSERT_NEXT(a_group_continues, clk, rst_n,
                   out_xfer && grp_r.cnt != 2'd1, out_valid, "group lost mid-drain")

endmodule

`default_nettype wire

### design/jsu_decode.sv
// ----------------------------------------------------------------------------
// JSON string unescape: byte decoder
// Holds the escape state and turns each accepted byte into a group of zero
// to three decoded bytes in one pass of logic.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  output jsu_pkg::jsu_group_t     grp
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_HEX3   = 3'd5
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic        stop_r, stop_nxt;
  logic [7:0]  held_r [3];
  logic [7:0]  held_nxt [3];

  logic [7:0]  res [3];
  logic [1:0]  n;
  logic [1:0]  j;
  logic [4:0]  hv;
  logic [7:0]  buf0, buf1;

  assign hv   = jsu_pkg::hex_value(in_byte);
  assign j    = 2'(mode_r - MODE_HEX0);
  // gathered bytes with the current byte in the slot it would fill
  assign buf0 = (j == 2'd0) ? in_byte : held_r[0];
  assign buf1 = (j == 2'd1) ? in_byte : held_r[1];

  always_comb begin
    mode_nxt = mode_r;
    cp_nxt   = cp_r;
    stop_nxt = stop_r;
    held_nxt = held_r;
    res      = '{default: 8'h00};
    n        = 2'd0;
    case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_NORMAL;
        if (in_byte == jsu_pkg::CH_LOWER_U) begin
          if (!in_last) begin
            mode_nxt = MODE_HEX0;
            cp_nxt   = '0;
            stop_nxt = 1'b0;
          end
        end else begin
          res[0] = jsu_pkg::simple_escape(in_byte);
          n      = 2'd1;
        end
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (!stop_r) begin
          if (hv != jsu_pkg::HEX_NONE) begin
            cp_nxt = {cp_r[11:0], hv[3:0]};
          end else begin
            stop_nxt = 1'b1;
          end
        end
        if (j == 2'd3) begin
          mode_nxt = MODE_NORMAL;
          if (cp_nxt < jsu_pkg::UTF8_LIM1) begin
            res[0] = cp_nxt[7:0];
            n      = 2'd1;
          end else if (cp_nxt < jsu_pkg::UTF8_LIM2) begin
            res[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp_nxt[10:6]};
            res[1] = jsu_pkg::UTF8_CONT  | {2'b00, cp_nxt[5:0]};
            n      = 2'd2;
          end else begin
            res[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp_nxt[15:12]};
            res[1] = jsu_pkg::UTF8_CONT  | {2'b00, cp_nxt[11:6]};
            res[2] = jsu_pkg::UTF8_CONT  | {2'b00, cp_nxt[5:0]};
            n      = 2'd3;
          end
        end else if (in_last) begin
          // short \u at end: drop the 'u', decode the gathered bytes as body
          mode_nxt = MODE_NORMAL;
          case (j)
            2'd0: begin
              res[0] = buf0;
              n      = 2'd1;
            end
            2'd1: begin
              if (buf0 == jsu_pkg::CH_BACKSLASH) begin
                if (buf1 != jsu_pkg::CH_LOWER_U) begin
                  res[0] = jsu_pkg::simple_escape(buf1);
                  n      = 2'd1;
                end
              end else begin
                res[0] = buf0;
                res[1] = buf1;
                n      = 2'd2;
              end
            end
            default: begin
              if (buf0 == jsu_pkg::CH_BACKSLASH) begin
                if (buf1 != jsu_pkg::CH_LOWER_U) begin
                  res[0] = jsu_pkg::simple_escape(buf1);
                  res[1] = in_byte;
                  n      = 2'd2;
                end else begin
                  res[0] = in_byte;
                  n      = 2'd1;
                end
              end else if (buf1 == jsu_pkg::CH_BACKSLASH) begin
                res[0] = buf0;
                if (in_byte != jsu_pkg::CH_LOWER_U) begin
                  res[1] = jsu_pkg::simple_escape(in_byte);
                  n      = 2'd2;
                end else begin
                  n      = 2'd1;
                end
              end else begin
                res[0] = buf0;
                res[1] = buf1;
                res[2] = in_byte;
                n      = 2'd3;
              end
            end
          endcase
        end else begin
          held_nxt[j] = in_byte;
          mode_nxt    = mode_t'(mode_r + 3'd1);
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (in_byte == jsu_pkg::CH_BACKSLASH && !in_last) begin
          mode_nxt = MODE_ESC;
        end else begin
          res[0] = in_byte;
          n      = 2'd1;
        end
      end
    endcase
    if (in_last) begin
      mode_nxt = MODE_NORMAL;
    end
  end

  // last byte with nothing decoded still yields a bare end marker
  always_comb begin
    grp.bytes    = {res[2], res[1], res[0]};
    grp.cnt      = n;
    grp.has_byte = 1'b1;
    grp.last     = in_last;
    if (in_last && n == 2'd0) begin
      grp.cnt      = 2'd1;
      grp.has_byte = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      cp_r   <= '0;
      stop_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cp_r   <= cp_nxt;
      stop_r <= stop_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire
